[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro takes a label, an antecedent and a consequent; clock and reset
// names are fixed to the house names clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants, codes and types of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int ST_W     = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// wide enough for a position and for the count
	localparam int IDX_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// commands
	localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd7;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	localparam logic [VAL_W-1:0] VAL_FLAG = {VAL_W{1'b1}};

	// broadcast control to the cell row
	typedef struct packed {
		logic ins;   // open a gap at the hit cell, shift later cells up
		logic del;   // close the gap at the hit cell, shift later cells down
	} cell_ctl_t;

endpackage

[sv/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the list row: holds one entry and takes its left or
// right neighbor's entry when the row shifts, or the new item at an insert.
// ----------------------------------------------------------------------------
module ils_cell (
	input  logic                      clk,
	input  ils_pkg::cell_ctl_t        ctl,
	input  logic                      hit,
	input  logic                      past_in,
	output logic                      past_out,
	input  logic [ils_pkg::VAL_W-1:0] left_val,
	input  logic [ils_pkg::VAL_W-1:0] right_val,
	input  logic [ils_pkg::VAL_W-1:0] item_value,
	output logic [ils_pkg::VAL_W-1:0] entry
);
	import ils_pkg::*;

	logic [VAL_W-1:0] entry_q;

	// pass on "target lies left of here" to the next cell
	assign past_out = past_in | hit;

	// shift up past the gap, fill the gap, or shift down from the target on
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (past_in) begin
				entry_q <= left_val;
			end else if (hit) begin
				entry_q <= item_value;
			end
		end else if (ctl.del) begin
			if (past_in || hit) begin
				entry_q <= right_val;
			end
		end
	end

	assign entry = entry_q;

endmodule

[sv/indexed_list_store_unit.sv]
// Latency: a command accepted at one edge gives its result, marked by done,
// in the next cycle; one command per cycle sustained while busy is low.
// The rate is set by the row of cells, which shifts all entries at once.
// busy is high in reset and in the first cycle after reset release.
// Reset clears the count and control; entries are left as they are.
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered store of up to CAPACITY signed words with insert, remove, read and
// count commands, built as a row of shifting cells.
// ----------------------------------------------------------------------------
module indexed_list_store_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ils_pkg::CMD_W-1:0] command,
	input  logic [ils_pkg::POS_W-1:0] position,
	input  logic signed [ils_pkg::VAL_W-1:0] item_value,
	output logic                      done,
	output logic signed [ils_pkg::VAL_W-1:0] read_value,
	output logic [ils_pkg::CNT_W-1:0] entry_count,
	output logic [ils_pkg::ST_W-1:0]  status
);
	import ils_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [VAL_W-1:0]     read_value_q;
	logic [CNT_W-1:0]     count_q;
	logic [ST_W-1:0]      status_q;

	logic                 accept;
	logic [IDX_W-1:0]     cnt_w;
	logic [IDX_W-1:0]     at_w;
	logic [ST_W-1:0]      st_c;
	logic [VAL_W-1:0]     val_c;
	logic [CNT_W-1:0]     count_nxt;
	logic                 do_ins;
	logic                 do_del;
	logic [VAL_W-1:0]     sel_val;
	cell_ctl_t            ctl;

	logic [CAPACITY-1:0]  hit;
	logic [CAPACITY:0]    past;
	logic [VAL_W-1:0]     cell_val [CAPACITY];

	assign accept = start & ~busy_q;
	assign cnt_w  = IDX_W'(count_q);

	// pick the target position of the command
	always_comb begin
		unique case (command)
			CMD_ADD_FRONT, CMD_REM_FRONT: at_w = '0;
			CMD_ADD_BACK:                 at_w = cnt_w;
			CMD_REM_BACK:                 at_w = cnt_w - IDX_W'(1);
			default:                      at_w = IDX_W'(position);
		endcase
	end

	// one-hot target select and the read-out of the target entry
	always_comb begin
		sel_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i]  = (at_w == IDX_W'(i));
			sel_val = sel_val | (cell_val[i] & {VAL_W{hit[i]}});
		end
	end

	// decide status, result value and row operation
	always_comb begin
		st_c   = ST_OK;
		val_c  = '0;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (command)
			CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT: begin
				if (at_w > cnt_w) begin
					st_c = ST_RANGE;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					st_c = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
				if (count_q == '0) begin
					st_c = ST_EMPTY;
				end else if (at_w >= cnt_w) begin
					st_c = ST_RANGE;
				end else begin
					do_del = 1'b1;
					val_c  = sel_val;
				end
			end
			CMD_READ_AT: begin
				if (at_w >= cnt_w) begin
					st_c = ST_RANGE;
				end else begin
					val_c = sel_val;
				end
			end
			default: begin
			end
		endcase
		if (st_c != ST_OK) begin
			val_c = VAL_FLAG;
		end
	end

	assign ctl.ins = accept & do_ins;
	assign ctl.del = accept & do_del;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// row of cells, each linked to its neighbors
	assign past[0] = 1'b0;
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VAL_W-1:0] lv;
		logic [VAL_W-1:0] rv;
		if (g == 0) begin : g_first
			assign lv = '0;
		end else begin : g_mid_l
			assign lv = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign rv = cell_val[g];
		end else begin : g_mid_r
			assign rv = cell_val[g+1];
		end
		ils_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.hit        (hit[g]),
			.past_in    (past[g]),
			.past_out   (past[g+1]),
			.left_val   (lv),
			.right_val  (rv),
			.item_value (item_value),
			.entry      (cell_val[g])
		);
	end

	// control registers: hold busy for one cycle out of reset, advance count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= val_c;
			status_q     <= st_c;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign read_value  = read_value_q;
	assign entry_count = count_q;
	assign status      = status_q;

endmodule

[sv/ils_checker.sv]
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ils_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [ils_pkg::CMD_W-1:0] command,
	input logic [ils_pkg::POS_W-1:0] position,
	input logic [ils_pkg::VAL_W-1:0] item_value,
	input logic                      done,
	input logic [ils_pkg::VAL_W-1:0] read_value,
	input logic [ils_pkg::CNT_W-1:0] entry_count,
	input logic [ils_pkg::ST_W-1:0]  status
);
	import ils_pkg::*;

	// every accepted command gives a result beat next cycle, and only then
	`ASSERT_NEXT(a_accept_done, start && !busy, done)
	`ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	// flagged results carry -1
	`ASSERT_SAME(a_flag_value, done && status != ST_OK, read_value == VAL_FLAG)
	// the count never passes the capacity, and a full result means a full store
	`ASSERT_SAME(a_count_bound, done, entry_count <= CNT_W'(CAPACITY) &&
		(status != ST_FULL || entry_count == CNT_W'(CAPACITY)))

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (.*);
